/* sv/msra_pkg.sv */
package msra_pkg;

   // Largest number of slope elements per axis; the average store holds two axes.
   localparam int MAX_SUBAPS = 256;
   localparam int POS_W      = (MAX_SUBAPS > 1) ? $clog2(MAX_SUBAPS) : 1;
   localparam int ADDR_W     = $clog2(2 * MAX_SUBAPS);
   localparam int CNT_W      = 11;

   localparam int SLOPE_W  = 16;
   localparam int AVG_W    = 32;
   localparam int SUM_W    = 41;
   localparam int CFG_W    = 17;
   localparam int DCOUNT_W = $clog2(SUM_W + 1);

   typedef logic signed [SLOPE_W-1:0] slope_type;
   typedef logic signed [AVG_W-1:0]   avg_type;
   typedef logic        [8:0]         count_type;
   typedef logic        [16:0]        weight_type;
   typedef logic        [1:0]         csr_index_type;
   typedef logic        [CFG_W-1:0]   csr_data_type;

   localparam csr_index_type CSR_NUM_SUBAPS   = 2'd0;
   localparam csr_index_type CSR_USED_SUBAPS  = 2'd1;
   localparam csr_index_type CSR_BLEND_WEIGHT = 2'd2;

   localparam count_type  NUM_SUBAPS_RESET   = 9'd256;
   localparam count_type  USED_SUBAPS_RESET  = 9'd256;
   localparam weight_type BLEND_WEIGHT_RESET = 17'd6554;
   localparam weight_type WEIGHT_ONE         = 17'd65536;

   localparam avg_type AVG_MAX = 32'sh7FFF_FFFF;
   localparam avg_type AVG_MIN = 32'sh8000_0000;

endpackage

/* sv/msra_if.sv */
interface msra_req_if;
   logic                valid;
   logic                ready;
   msra_pkg::slope_type slope;
   logic                subap_used;

   modport source (output valid, slope, subap_used, input ready);
   modport sink   (input valid, slope, subap_used, output ready);
endinterface

interface msra_rsp_if;
   logic                valid;
   logic                ready;
   msra_pkg::slope_type masked_slope;
   msra_pkg::avg_type   average;
   logic                axis;
   logic                mean_valid;
   msra_pkg::avg_type   axis_mean;
   msra_pkg::avg_type   running_min;
   msra_pkg::avg_type   running_max;

   modport source (output valid, masked_slope, average, axis, mean_valid, axis_mean,
                   running_min, running_max, input ready);
   modport sink   (input valid, masked_slope, average, axis, mean_valid, axis_mean,
                   running_min, running_max, output ready);
endinterface

interface msra_csr_if;
   logic                    valid;
   logic                    ready;
   msra_pkg::csr_index_type index;
   msra_pkg::csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/masked_slope_running_average_core.sv */
// Masked slope running average. Each req beat carries one slope sample and its
// subaperture-used flag; a frame is num_subaps X samples followed by num_subaps
// Y samples. Every beat yields one rsp beat holding the masked sample, the
// element's updated Q16.16 running average (weight 1.0 during the first frame
// after reset, blend_weight afterwards), the global running min and max of all
// averages since reset, and on the last element of an axis the axis mean (sum
// of that axis' averages over used_subaps, truncated toward zero, saturated).
// A single multiplier is time-shared by a small sequencer: one pass forms
// sample*weight, a second forms old*(1-weight), then the blend is added and the
// store, sum, min and max are updated. An ordinary element steps through
// mul_new, mul_old, blend, update and finish; an axis' last element adds the
// bit-serial divider that forms the mean. req ready is high only while the
// sequencer is idle; a finished rsp beat waits in the output register, so the
// next sample can be accepted while it is still pending. The average store is
// not cleared after reset: the first frame ignores its contents, so no
// clearing pass is needed. Configuration is written through the csr channel,
// which is always ready; indexes beyond blend_weight are dropped.
module masked_slope_running_average_core (
   input  logic         clock,
   input  logic         reset,
   msra_req_if.sink     req_chan,
   msra_rsp_if.source   rsp_chan,
   msra_csr_if.sink     csr_chan
);
   import msra_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_BLEND,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Configuration registers
   count_type  num_subaps_ff;
   count_type  used_subaps_ff;
   weight_type blend_weight_ff;

   // Frame tracking and global statistics
   state_type             state_ff;
   logic [8:0]            element_position_ff;
   logic                  axis_ff;
   logic                  first_frame_ff;
   logic signed [SUM_W-1:0] axis_sum_ff;
   avg_type               min_ff;
   avg_type               max_ff;

   // Per-beat working registers
   slope_type             masked_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic                  item_axis_ff;
   logic                  last_ff;
   avg_type               old_ff;
   logic signed [33:0]    new_term_ff;
   logic signed [50:0]    old_term_ff;
   avg_type               avg_ff;

   // Divider registers: dividend shifts out as the quotient shifts in
   logic [SUM_W-1:0]      dvd_ff;
   logic [9:0]            rem_ff;
   logic                  neg_ff;
   logic [DCOUNT_W-1:0]   div_count_ff;

   // Output register
   logic       rsp_valid_ff;
   slope_type  rsp_masked_ff;
   avg_type    rsp_average_ff;
   logic       rsp_axis_ff;
   logic       rsp_mean_valid_ff;
   avg_type    rsp_mean_ff;
   avg_type    rsp_min_ff;
   avg_type    rsp_max_ff;

   avg_type average_store [2*MAX_SUBAPS];

   logic                    req_accept;
   logic                    rsp_free;
   logic [POS_W-1:0]        pos_in;
   logic [CNT_W-1:0]        n_eff;
   logic                    last_in;
   logic [ADDR_W-1:0]       addr_in;
   logic signed [17:0]      weight_in;
   logic signed [32:0]      mul_a;
   logic signed [17:0]      mul_b;
   logic signed [50:0]      product;
   logic signed [50:0]      blend_sum;
   avg_type                 avg_in;
   logic signed [SUM_W-1:0] sum_in;
   logic [8:0]              divisor;
   logic [9:0]              rem_shift;
   logic [10:0]             trial;
   logic signed [SUM_W:0]   quot_signed;
   avg_type                 mean_in;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Element index, clamped to the store depth; axis ends at the effective count
   always_comb begin
      if (CNT_W'(element_position_ff) >= CNT_W'(MAX_SUBAPS)) begin
         pos_in = POS_W'(MAX_SUBAPS - 1);
      end else begin
         pos_in = element_position_ff[POS_W-1:0];
      end
      if (num_subaps_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (CNT_W'(num_subaps_ff) > CNT_W'(MAX_SUBAPS)) begin
         n_eff = CNT_W'(MAX_SUBAPS);
      end else begin
         n_eff = CNT_W'(num_subaps_ff);
      end
      last_in = (CNT_W'(pos_in) + CNT_W'(1)) >= n_eff;
      addr_in = axis_ff ? ADDR_W'(MAX_SUBAPS) + ADDR_W'(pos_in) : ADDR_W'(pos_in);
   end

   // New-sample weight: full weight in the first frame, clamp above one
   always_comb begin
      if (first_frame_ff || blend_weight_ff > WEIGHT_ONE) begin
         weight_in = $signed({1'b0, WEIGHT_ONE});
      end else begin
         weight_in = $signed({1'b0, blend_weight_ff});
      end
   end

   // Shared multiplier: sample*w on the first pass, old*(1-w) on the second
   always_comb begin
      if (state_ff == ST_MUL_NEW) begin
         mul_a = 33'(masked_ff);
         mul_b = weight_in;
      end else begin
         mul_a = first_frame_ff ? '0 : 33'(old_ff);
         mul_b = $signed({1'b0, WEIGHT_ONE}) - weight_in;
      end
      product = mul_a * mul_b;
   end

   // Floor of the blend splits exactly since sample*w is an integer
   assign blend_sum = 51'(new_term_ff) + (old_term_ff >>> 16);
   assign avg_in    = blend_sum[AVG_W-1:0];
   assign sum_in    = axis_sum_ff + SUM_W'(avg_ff);

   // One restoring-division step per cycle
   assign divisor   = (used_subaps_ff == '0) ? 9'd1 : used_subaps_ff;
   assign rem_shift = {rem_ff[8:0], dvd_ff[SUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor};

   always_comb begin
      quot_signed = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      if (!last_ff) begin
         mean_in = '0;
      end else if (quot_signed > (SUM_W+1)'(AVG_MAX)) begin
         mean_in = AVG_MAX;
      end else if (quot_signed < (SUM_W+1)'(AVG_MIN)) begin
         mean_in = AVG_MIN;
      end else begin
         mean_in = quot_signed[AVG_W-1:0];
      end
   end

   // Average store: read at accept, write back at update
   always_ff @(posedge clock) begin
      if (req_accept) begin
         old_ff <= average_store[addr_in];
      end
      if (state_ff == ST_UPDATE) begin
         average_store[addr_ff] <= avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_subaps_ff       <= NUM_SUBAPS_RESET;
         used_subaps_ff      <= USED_SUBAPS_RESET;
         blend_weight_ff     <= BLEND_WEIGHT_RESET;
         state_ff            <= ST_IDLE;
         element_position_ff <= '0;
         axis_ff             <= 1'b0;
         first_frame_ff      <= 1'b1;
         axis_sum_ff         <= '0;
         min_ff              <= AVG_MAX;
         max_ff              <= AVG_MIN;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_NUM_SUBAPS:   num_subaps_ff   <= csr_chan.data[8:0];
               CSR_USED_SUBAPS:  used_subaps_ff  <= csr_chan.data[8:0];
               CSR_BLEND_WEIGHT: blend_weight_ff <= csr_chan.data;
               default: ;
            endcase
         end

         // in finish a leaving beat is replaced by the new one below
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  masked_ff    <= req_chan.subap_used ? req_chan.slope : '0;
                  addr_ff      <= addr_in;
                  item_axis_ff <= axis_ff;
                  last_ff      <= last_in;
                  // advance the position now; axis and frame flags move at update
                  element_position_ff <= last_in ? '0 : 9'(CNT_W'(pos_in) + CNT_W'(1));
                  state_ff     <= ST_MUL_NEW;
               end
            end
            ST_MUL_NEW: begin
               new_term_ff <= product[33:0];
               state_ff    <= ST_MUL_OLD;
            end
            ST_MUL_OLD: begin
               old_term_ff <= product;
               state_ff    <= ST_BLEND;
            end
            ST_BLEND: begin
               avg_ff   <= avg_in;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (avg_ff < min_ff) begin
                  min_ff <= avg_ff;
               end
               if (avg_ff > max_ff) begin
                  max_ff <= avg_ff;
               end
               if (last_ff) begin
                  axis_sum_ff  <= '0;
                  neg_ff       <= sum_in[SUM_W-1];
                  dvd_ff       <= sum_in[SUM_W-1] ? unsigned'(-sum_in) : unsigned'(sum_in);
                  rem_ff       <= '0;
                  div_count_ff <= DCOUNT_W'(SUM_W);
                  axis_ff      <= !axis_ff;
                  if (axis_ff) begin
                     first_frame_ff <= 1'b0;
                  end
                  state_ff     <= ST_DIVIDE;
               end else begin
                  axis_sum_ff <= sum_in;
                  state_ff    <= ST_FINISH;
               end
            end
            ST_DIVIDE: begin
               if (!trial[10]) begin
                  rem_ff <= trial[9:0];
               end else begin
                  rem_ff <= rem_shift;
               end
               dvd_ff       <= {dvd_ff[SUM_W-2:0], !trial[10]};
               div_count_ff <= div_count_ff - DCOUNT_W'(1);
               if (div_count_ff == DCOUNT_W'(1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold until the output register can take the beat
               if (rsp_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_masked_ff     <= masked_ff;
                  rsp_average_ff    <= avg_ff;
                  rsp_axis_ff       <= item_axis_ff;
                  rsp_mean_valid_ff <= last_ff;
                  rsp_mean_ff       <= mean_in;
                  rsp_min_ff        <= min_ff;
                  rsp_max_ff        <= max_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.masked_slope = rsp_masked_ff;
   assign rsp_chan.average      = rsp_average_ff;
   assign rsp_chan.axis         = rsp_axis_ff;
   assign rsp_chan.mean_valid   = rsp_mean_valid_ff;
   assign rsp_chan.axis_mean    = rsp_mean_ff;
   assign rsp_chan.running_min  = rsp_min_ff;
   assign rsp_chan.running_max  = rsp_max_ff;

`ifndef SYNTHESIS
   a_mean_zero_when_invalid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_mean_valid_ff |-> rsp_mean_ff == '0)
      else $error("axis_mean nonzero without mean_valid");

   a_average_within_bounds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_min_ff <= rsp_average_ff && rsp_average_ff <= rsp_max_ff)
      else $error("average outside running min/max");

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("rsp beat raised outside finish step");

   a_divide_on_axis_end : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> last_ff && div_count_ff != '0)
      else $error("divider running on a non-final element");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msra_pkg::*;

   localparam int     CLK_PERIOD      = 4;
   localparam int     RESET_CYCLES    = 8;
   localparam int     RANDOM_ITEMS    = 840;
   localparam int     RSP_HOLD_CYCLES = 300;
   // Longest per-element cycle: read-modify-write plus the bit-serial divide.
   localparam int     SETTLE_CYCLES   = 64;
   localparam int     MAX_REPORTS     = 50;
   localparam longint ONE_Q16         = 65536;

   // Index past the last register; the block must drop writes to it.
   localparam csr_index_type CSR_SPARE = 2'd3;

   // One expected rsp beat, field for field.
   typedef struct packed {
      slope_type masked_slope;
      avg_type   average;
      logic      axis;
      logic      mean_valid;
      avg_type   axis_mean;
      avg_type   running_min;
      avg_type   running_max;
   } blend_result_type;

   typedef enum logic [1:0] {ROW_BEAT, ROW_CSR, ROW_FILL} row_kind_type;

   // Directed stimulus row. Rows flagged typed carry a hand-written masked
   // slope and average; all other fields come from the predictor.
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type index;
      csr_data_type  data;
      slope_type     slope;
      logic          used;
      logic          typed;
      slope_type     want_masked;
      avg_type       want_avg;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 34;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // First frame after reset: weight is one, so average = masked << 16.
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 32'sh7FFF_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 32'sh8000_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 32'sh0000_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'shFFFF, 1'b1, 1'b1, 16'shFFFF, 32'shFFFF_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh0001, 1'b1, 1'b1, 16'sh0001, 32'sh0001_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh7FFF, 1'b0, 1'b1, 16'sh0000, 32'sh0000_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh8000, 1'b0, 1'b1, 16'sh0000, 32'sh0000_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh5555, 1'b1, 1'b1, 16'sh5555, 32'sh5555_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'shAAAA, 1'b1, 1'b1, 16'shAAAA, 32'shAAAA_0000},
      // Finish the first frame so every store entry of both axes is written.
      '{ROW_FILL, CSR_NUM_SUBAPS, 17'd0, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 32'sh0000_0000},
      // Weight of exactly one: old average drops out.
      '{ROW_CSR, CSR_BLEND_WEIGHT, 17'd65536, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 32'sh7FFF_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh8000, 1'b0, 1'b1, 16'sh0000, 32'sh0000_0000},
      // Weight above one behaves as one.
      '{ROW_CSR, CSR_BLEND_WEIGHT, 17'h1FFFF, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 32'sh8000_0000},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh1234, 1'b1, 1'b1, 16'sh1234, 32'sh1234_0000},
      // Weight zero: average holds its old value.
      '{ROW_CSR, CSR_BLEND_WEIGHT, 17'd0, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'shFFFF, 1'b1, 1'b0, 16'sh0, 32'sh0},
      // Write to the spare index; nothing may change.
      '{ROW_CSR, CSR_SPARE, 17'h1FFFF, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0, 32'sh0},
      // Zero count acts as one; element six is past it, so the X axis ends here.
      '{ROW_CSR, CSR_NUM_SUBAPS, 17'd0, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh0064, 1'b1, 1'b0, 16'sh0, 32'sh0},
      // Zero divisor divides by one.
      '{ROW_CSR, CSR_USED_SUBAPS, 17'd0, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'shFF9C, 1'b1, 1'b0, 16'sh0, 32'sh0},
      '{ROW_CSR, CSR_NUM_SUBAPS, 17'd3, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_CSR, CSR_USED_SUBAPS, 17'd1, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_CSR, CSR_BLEND_WEIGHT, 17'd1, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh8000, 1'b1, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh0000, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_CSR, CSR_NUM_SUBAPS, 17'd1, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_BEAT, CSR_NUM_SUBAPS, 17'd0, 16'sh4000, 1'b1, 1'b0, 16'sh0, 32'sh0},
      // Count field all ones (upper data bits set too) clamps to the maximum.
      '{ROW_CSR, CSR_NUM_SUBAPS, 17'h1FFFF, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0},
      '{ROW_CSR, CSR_USED_SUBAPS, 17'd256, 16'sh0, 1'b0, 1'b0, 16'sh0, 32'sh0}
   };

   logic clock = 1'b0;
   logic reset;

   msra_req_if req_if ();
   msra_rsp_if rsp_if ();
   msra_csr_if csr_if ();

   masked_slope_running_average_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: its own copy of the averages, position, extremes
   // and register settings, advanced once per accepted req beat.
   // ------------------------------------------------------------------
   avg_type     avg_store [2*MAX_SUBAPS];
   int unsigned elem_pos;
   logic        cur_axis;
   logic        in_first_frame;
   longint      axis_total;
   avg_type     low_water;
   avg_type     high_water;
   count_type   cfg_num;
   count_type   cfg_used;
   weight_type  cfg_weight;

   blend_result_type pending_blends [$];

   int  error_count    = 0;
   int  beats_checked  = 0;
   int  means_checked  = 0;
   int  items_sent     = 0;
   int  csr_writes     = 0;
   int  held_cycles    = 0;
   bit  no_gaps        = 1'b0;
   bit  rsp_hold_req   = 1'b0;

   function automatic avg_type clamp32(longint v);
      if (v > longint'(AVG_MAX))
         return AVG_MAX;
      if (v < longint'(AVG_MIN))
         return AVG_MIN;
      return avg_type'(v);
   endfunction

   // Blend one sample into its element and return the beat it must produce.
   function automatic blend_result_type blend_sample(slope_type slope, logic used);
      blend_result_type  r;
      int unsigned       n;
      int unsigned       pos;
      logic [ADDR_W-1:0] addr;
      longint            m;
      longint            w;
      longint            prev;
      longint            acc;
      longint            divisor;
      avg_type           avg;

      m = 0;
      if (used)
         m = longint'(slope);

      // Clamp the count into 1..MAX_SUBAPS.
      n = 32'(cfg_num);
      if (n == 0)
         n = 1;
      if (n > MAX_SUBAPS)
         n = MAX_SUBAPS;

      pos  = (elem_pos >= MAX_SUBAPS) ? MAX_SUBAPS - 1 : elem_pos;
      addr = ADDR_W'((cur_axis ? MAX_SUBAPS : 0) + pos);

      // The first frame ignores the store and takes the sample whole.
      if (in_first_frame) begin
         w    = ONE_Q16;
         prev = 0;
      end else begin
         w    = (cfg_weight > WEIGHT_ONE) ? ONE_Q16 : longint'(cfg_weight);
         prev = longint'(avg_store[addr]);
      end

      // Exact convex blend, floored back to Q16.16.
      acc = m * w * ONE_Q16 + prev * (ONE_Q16 - w);
      avg = clamp32(acc >>> 16);
      avg_store[addr] = avg;

      axis_total += longint'(avg);
      if (avg < low_water)
         low_water = avg;
      if (avg > high_water)
         high_water = avg;

      r.masked_slope = slope_type'(m);
      r.average      = avg;
      r.axis         = cur_axis;
      r.mean_valid   = 1'b0;
      r.axis_mean    = '0;

      // Last element of the axis, or count shrunk under the current position.
      if (pos + 1 >= n) begin
         divisor      = (cfg_used == 0) ? 1 : longint'(cfg_used);
         r.axis_mean  = clamp32(axis_total / divisor);
         r.mean_valid = 1'b1;
         axis_total   = 0;
         elem_pos     = 0;
         if (cur_axis)
            in_first_frame = 1'b0;
         cur_axis = ~cur_axis;
      end else begin
         elem_pos = pos + 1;
      end

      r.running_min = low_water;
      r.running_max = high_water;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Random picks. Gaps are mostly short, a few long.
   // ------------------------------------------------------------------
   function automatic int idle_len();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 60)
         return 0;
      return idle_len();
   endfunction

   function automatic slope_type pick_slope();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return 16'sh7FFF;
      if (r < 6)
         return 16'sh8000;
      if (r < 8)
         return 16'sh0000;
      if (r < 10)
         return 16'shFFFF;
      return slope_type'($urandom);
   endfunction

   function automatic logic pick_used();
      return ($urandom_range(0, 99) < 80);
   endfunction

   // Counts and divisors: mostly small, with zero, one, full scale and the
   // clamped range above it; sometimes junk in the unused upper data bits.
   function automatic csr_data_type pick_count();
      int           r;
      csr_data_type v;
      r = $urandom_range(0, 99);
      if (r < 30)
         v = CFG_W'($urandom_range(1, 8));
      else if (r < 45)
         v = CFG_W'($urandom_range(9, 40));
      else if (r < 55)
         v = CFG_W'(256);
      else if (r < 63)
         v = '0;
      else if (r < 68)
         v = CFG_W'(1);
      else if (r < 78)
         v = CFG_W'($urandom_range(257, 511));
      else
         v = CFG_W'($urandom_range(41, 255));
      if ($urandom_range(0, 3) == 0)
         v[CFG_W-1:9] = 8'($urandom_range(0, 255));
      return v;
   endfunction

   function automatic csr_data_type pick_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 20)
         return WEIGHT_ONE;
      if (r < 30)
         return CFG_W'($urandom_range(65537, 131071));
      if (r < 40)
         return BLEND_WEIGHT_RESET;
      if (r < 45)
         return CFG_W'(1);
      if (r < 50)
         return CFG_W'(65535);
      return CFG_W'($urandom_range(0, 65535));
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers. Inputs move on the falling edge only.
   // ------------------------------------------------------------------

   // Offer one sample beat and hold it until accepted; log the expectation.
   task automatic send_slope(slope_type slope, logic used, logic typed,
                             slope_type want_masked, avg_type want_avg);
      int               gap;
      blend_result_type r;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.slope      <= slope;
      req_if.subap_used <= used;
      do
         @(posedge clock);
      while (!req_if.ready);
      r = blend_sample(slope, used);
      if (typed) begin
         r.masked_slope = want_masked;
         r.average      = want_avg;
      end
      pending_blends.push_back(r);
      items_sent++;
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_blends.size() != 0)
         @(posedge clock);
   endtask

   // Write a register once the block is idle: drop req valid, let every
   // pending beat come out, then issue the write.
   task automatic write_reg(csr_index_type idx, csr_data_type value);
      req_idle();
      wait_drained();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do
         @(posedge clock);
      while (!csr_if.ready);
      case (idx)
         CSR_NUM_SUBAPS:   cfg_num    = count_type'(value);
         CSR_USED_SUBAPS:  cfg_used   = count_type'(value);
         CSR_BLEND_WEIGHT: cfg_weight = weight_type'(value);
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side: random ready with stalls, quiet stretches and one long
   // hold-off on request.
   // ------------------------------------------------------------------
   initial begin
      int stall_left;
      int quiet_left;
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      quiet_left   = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            // Hold ready low long enough that the block backs up into req.
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
            held_cycles += RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (quiet_left > 0) begin
            rsp_if.ready <= 1'b1;
            quiet_left--;
         end else if ($urandom_range(0, 99) < 3) begin
            quiet_left = $urandom_range(50, 200);
            rsp_if.ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 30) begin
            stall_left = idle_len() - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: compare every accepted rsp beat with the oldest expectation.
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         if (error_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      blend_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         if (pending_blends.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("%0t ns: rsp beat with nothing expected, expected none, actual avg %h",
                        $time, rsp_if.average);
            error_count++;
         end else begin
            want = pending_blends.pop_front();
            check_field("masked_slope", 32'(want.masked_slope), 32'(rsp_if.masked_slope));
            check_field("average", want.average, rsp_if.average);
            check_field("axis", 32'(want.axis), 32'(rsp_if.axis));
            check_field("mean_valid", 32'(want.mean_valid), 32'(rsp_if.mean_valid));
            check_field("axis_mean", want.axis_mean, rsp_if.axis_mean);
            check_field("running_min", want.running_min, rsp_if.running_min);
            check_field("running_max", want.running_max, rsp_if.running_max);
            beats_checked++;
            if (want.mean_valid)
               means_checked++;
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("%0t ns: watchdog expired with %0d beats outstanding", $time,
               pending_blends.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, directed table, random phases, drain.
   // ------------------------------------------------------------------
   initial begin
      int random_sent;
      int phase;
      int len;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.slope      = '0;
      req_if.subap_used = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_NUM_SUBAPS;
      csr_if.data       = '0;

      elem_pos       = 0;
      cur_axis       = 1'b0;
      in_first_frame = 1'b1;
      axis_total     = 0;
      low_water      = AVG_MAX;
      high_water     = AVG_MIN;
      cfg_num        = NUM_SUBAPS_RESET;
      cfg_used       = USED_SUBAPS_RESET;
      cfg_weight     = BLEND_WEIGHT_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (DIRECTED[i]) begin
         case (DIRECTED[i].kind)
            ROW_BEAT: send_slope(DIRECTED[i].slope, DIRECTED[i].used, DIRECTED[i].typed,
                                 DIRECTED[i].want_masked, DIRECTED[i].want_avg);
            ROW_CSR:  write_reg(DIRECTED[i].index, DIRECTED[i].data);
            ROW_FILL: begin
               while (in_first_frame)
                  send_slope(pick_slope(), pick_used(), 1'b0, '0, '0);
            end
            default: ;
         endcase
      end

      // Random phases; each after the first may retune the registers while idle. Phase ends
      // land anywhere inside an axis, so lowered counts cut axes short.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase > 0) begin
            if ($urandom_range(0, 1))
               write_reg(CSR_NUM_SUBAPS, pick_count());
            if ($urandom_range(0, 1))
               write_reg(CSR_USED_SUBAPS, pick_count());
            if ($urandom_range(0, 1))
               write_reg(CSR_BLEND_WEIGHT, pick_weight());
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         // Back up the output once while the sender keeps pushing.
         if (phase == 2)
            rsp_hold_req = 1'b1;
         len = $urandom_range(20, 120);
         repeat (len)
            send_slope(pick_slope(), pick_used(), 1'b0, '0, '0);
         random_sent += len;
         phase++;
      end

      // Drain, then watch a while longer for stray beats.
      req_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d sample beats and %0d register writes; checked %0d result beats",
               items_sent, csr_writes, beats_checked);
      $display("including %0d axis means, with a %0d-cycle output hold-off.",
               means_checked, held_cycles);
      if (error_count == 0 && pending_blends.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
sv/msra_pkg.sv
sv/msra_if.sv
sv/masked_slope_running_average_core.sv
dv/tb_top.sv
